### rtl/tsnl_pkg.sv
// ----------------------------------------------------------------------------
// Twist speed norm limiter package
// Widths, register indexes, payload types and shared datapath step functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsnl_pkg;

    localparam int COMP_W    = 24;
    localparam int LIM_W     = 23;
    localparam int EN_W      = 6;
    localparam int NUM_AXES  = 6;
    localparam int SQ_W      = 48;
    localparam int LSQ_W     = 46;
    localparam int PROD_W    = 47;
    localparam int ROOT_W    = 24;
    localparam int SREM_W    = 27;
    localparam int STEP_BITS = 3;
    localparam int STEPS     = 8;
    localparam int IDX_W     = 2;
    localparam int CFG_W     = 23;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0] A_LAST = CNT_W'(STEPS + 1);
    localparam logic [CNT_W-1:0] B_LAST = CNT_W'(STEPS);

    localparam logic [IDX_W-1:0] REG_LINEAR_LIMIT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ANGULAR_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_AXIS_ENABLE   = 2'd2;

    localparam logic [LIM_W-1:0] LIM_RESET = 23'd65536;
    localparam logic [EN_W-1:0]  EN_RESET  = 6'h3F;

    typedef logic [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] lin_x;
        logic signed [COMP_W-1:0] lin_y;
        logic signed [COMP_W-1:0] lin_z;
        logic signed [COMP_W-1:0] ang_x;
        logic signed [COMP_W-1:0] ang_y;
        logic signed [COMP_W-1:0] ang_z;
    } cmd_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_lin_x;
        logic signed [COMP_W-1:0] out_lin_y;
        logic signed [COMP_W-1:0] out_lin_z;
        logic signed [COMP_W-1:0] out_ang_x;
        logic signed [COMP_W-1:0] out_ang_y;
        logic signed [COMP_W-1:0] out_ang_z;
        logic                     linear_clamped;
        logic                     angular_clamped;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic sum;
        logic step;
    } norm_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [COMP_W-1:0] rem;
        logic              qbit;
    } div_st_t;

    function automatic comp_t mag(input comp_t v);
        return v[COMP_W-1] ? (~v) + COMP_W'(1) : v;
    endfunction

    function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [1:0] pair);
        logic [SREM_W-1:0] r2;
        logic [SREM_W-1:0] trial;
        sqrt_st_t          res;
        r2    = {st.rem[SREM_W-3:0], pair};
        trial = {1'b0, st.root, 2'b01};
        if (r2 >= trial)
        begin
            res.rem  = r2 - trial;
            res.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = r2;
            res.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic div_st_t div_step(input comp_t rem, input comp_t d, input logic b);
        logic [COMP_W:0] r2;
        logic [COMP_W:0] dd;
        div_st_t         res;
        r2 = {rem, b};
        dd = {1'b0, d};
        if (r2 >= dd)
        begin
            res.rem  = COMP_W'(r2 - dd);
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = COMP_W'(r2);
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/tsnl_if.sv
// ----------------------------------------------------------------------------
// Twist speed norm limiter channels
// Valid/ready channels for commands, responses and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsnl_cmd_if;
    logic            valid;
    logic            ready;
    tsnl_pkg::cmd_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsnl_rsp_if;
    logic            valid;
    logic            ready;
    tsnl_pkg::rsp_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsnl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsnl_pkg::IDX_W-1:0]      idx;
    logic [tsnl_pkg::CFG_W-1:0]      wdata;
    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/tsnl_norm_lane.sv
// ----------------------------------------------------------------------------
// Norm lane
// Squares one triple, compares against the limit and extracts the integer
// square root three bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsnl_norm_lane (
    input  logic                                clk,
    input  tsnl_pkg::norm_ctl_t                 ctl,
    input  logic [2:0][tsnl_pkg::COMP_W-1:0]    vec,
    input  logic [tsnl_pkg::LIM_W-1:0]          lim,
    output logic [2:0][tsnl_pkg::COMP_W-1:0]    vec_q,
    output logic [2:0][tsnl_pkg::PROD_W-1:0]    prod,
    output logic [tsnl_pkg::ROOT_W-1:0]         norm,
    output logic                                clamp
);
    import tsnl_pkg::*;

    comp_t                  mag_a [3];
    logic [SQ_W-1:0]        sq_reg [3];
    logic [2:0][PROD_W-1:0] prod_reg;
    logic [2:0][COMP_W-1:0] vec_reg;
    logic [LSQ_W-1:0]       limsq_reg;
    logic [SQ_W-1:0]        s_reg;
    logic [SQ_W-1:0]        sum;
    sqrt_st_t               st_reg;
    sqrt_st_t               chain [STEP_BITS+1];
    logic                   clamp_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a[i] = mag(vec[i]);
        end
        sum      = sq_reg[0] + sq_reg[1] + sq_reg[2];
        chain[0] = st_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            chain[k+1] = sqrt_step(chain[k], s_reg[SQ_W-1-2*k -: 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= SQ_W'(mag_a[i]) * SQ_W'(mag_a[i]);
                prod_reg[i] <= PROD_W'(mag_a[i]) * PROD_W'(lim);
            end
            vec_reg   <= vec;
            limsq_reg <= LSQ_W'(lim) * LSQ_W'(lim);
        end
        if (ctl.sum)
        begin
            s_reg     <= sum;
            clamp_reg <= (sum > SQ_W'(limsq_reg));
            st_reg    <= '0;
        end
        else if (ctl.step)
        begin
            s_reg  <= s_reg << (2 * STEP_BITS);
            st_reg <= chain[STEP_BITS];
        end
    end

    assign vec_q = vec_reg;
    assign prod  = prod_reg;
    assign norm  = st_reg.root;
    assign clamp = clamp_reg;

endmodule

`default_nettype wire

### rtl/tsnl_div_lane.sv
// ----------------------------------------------------------------------------
// Divide lane
// Scales one component by limit/norm with a restoring divider, three
// quotient bits per cycle, and restores the sign; an unclamped component passes unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsnl_div_lane (
    input  logic                          clk,
    input  tsnl_pkg::div_ctl_t            ctl,
    input  logic [tsnl_pkg::COMP_W-1:0]   v,
    input  logic [tsnl_pkg::PROD_W-1:0]   prod,
    input  logic [tsnl_pkg::ROOT_W-1:0]   d,
    input  logic                          clamp,
    output logic [tsnl_pkg::COMP_W-1:0]   res
);
    import tsnl_pkg::*;

    comp_t   rem_reg;
    comp_t   low_reg;
    comp_t   q_reg;
    comp_t   q_next;
    comp_t   d_reg;
    comp_t   v_reg;
    logic    clamp_reg;
    div_st_t dchain [STEP_BITS+1];

    always_comb
    begin
        dchain[0].rem  = rem_reg;
        dchain[0].qbit = 1'b0;
        q_next         = q_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            dchain[k+1] = div_step(dchain[k].rem, d_reg, low_reg[COMP_W-1-k]);
            q_next      = {q_next[COMP_W-2:0], dchain[k+1].qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg   <= COMP_W'(prod[PROD_W-1:COMP_W]);
            low_reg   <= prod[COMP_W-1:0];
            q_reg     <= '0;
            d_reg     <= d;
            v_reg     <= v;
            clamp_reg <= clamp;
        end
        else if (ctl.step)
        begin
            rem_reg <= dchain[STEP_BITS].rem;
            low_reg <= low_reg << STEP_BITS;
            q_reg   <= q_next;
        end
    end

    assign res = clamp_reg ? (v_reg[COMP_W-1] ? (~q_reg) + COMP_W'(1) : q_reg) : v_reg;

endmodule

`default_nettype wire

### rtl/tsnl_merge.sv
// ----------------------------------------------------------------------------
// Merge stage
// Masks disabled axes, joins the lane results with the clamp flags and
// holds the response transaction until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsnl_merge (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic [tsnl_pkg::NUM_AXES-1:0][tsnl_pkg::COMP_W-1:0] comp,
    input  logic                                           lf,
    input  logic                                           af,
    input  logic [tsnl_pkg::EN_W-1:0]                      en,
    input  logic                                           ready,
    output logic                                           valid,
    output tsnl_pkg::rsp_t                                 data
);
    import tsnl_pkg::*;

    logic [NUM_AXES-1:0][COMP_W-1:0] m;
    rsp_t                            data_reg;
    rsp_t                            data_next;
    logic                            valid_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            m[i] = en[i] ? comp[i] : '0;
        end
        data_next.out_lin_x       = m[0];
        data_next.out_lin_y       = m[1];
        data_next.out_lin_z       = m[2];
        data_next.out_ang_x       = m[3];
        data_next.out_ang_y       = m[4];
        data_next.out_ang_z       = m[5];
        data_next.linear_clamped  = lf;
        data_next.angular_clamped = af;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

### rtl/twist_speed_norm_limiter_unit.sv
// ----------------------------------------------------------------------------
// Twist speed norm limiter
// The norm lanes (square, sum, then 8 root steps of 3 bits) hand off to the
// divide lanes, which overlap them; a new command is taken while the norm lanes
// are idle or at that hand-off, which waits for the divide lanes to be free.
// Reset: async active low; clears handshake state, limits 1.0, all axes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twist_speed_norm_limiter_unit (
    input  logic        clk,
    input  logic        rst_n,
    tsnl_cmd_if.sink    cmd,
    tsnl_rsp_if.source  rsp,
    tsnl_cfg_if.sink    cfg
);
    import tsnl_pkg::*;

    logic [LIM_W-1:0]  lin_lim_reg;
    logic [LIM_W-1:0]  ang_lim_reg;
    logic [EN_W-1:0]   en_reg;
    logic              a_busy_reg;
    logic [CNT_W-1:0]  a_cnt_reg;
    logic              b_busy_reg;
    logic [CNT_W-1:0]  b_cnt_reg;
    logic              lf_reg;
    logic              af_reg;
    logic              cmd_acc;
    logic              h_ab;
    logic              h_bo;
    norm_ctl_t         nctl;
    div_ctl_t          dctl;

    logic [2:0][COMP_W-1:0]          lin_vec;
    logic [2:0][COMP_W-1:0]          ang_vec;
    logic [2:0][PROD_W-1:0]          lin_prod;
    logic [2:0][PROD_W-1:0]          ang_prod;
    logic [ROOT_W-1:0]               lin_norm;
    logic [ROOT_W-1:0]               ang_norm;
    logic                            lin_cl;
    logic                            ang_cl;
    logic [NUM_AXES-1:0][COMP_W-1:0] v6;
    logic [NUM_AXES-1:0][PROD_W-1:0] p6;
    logic [NUM_AXES-1:0][ROOT_W-1:0] n6;
    logic [NUM_AXES-1:0]             c6;
    logic [NUM_AXES-1:0][COMP_W-1:0] r6;

    assign h_ab      = a_busy_reg && (a_cnt_reg == A_LAST) && !b_busy_reg;
    assign h_bo      = b_busy_reg && (b_cnt_reg == B_LAST) && (!rsp.valid || rsp.ready);
    assign cmd.ready = !a_busy_reg || h_ab;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign nctl.load = cmd_acc;
    assign nctl.sum  = a_busy_reg && (a_cnt_reg == '0);
    assign nctl.step = a_busy_reg && (a_cnt_reg != '0) && (a_cnt_reg != A_LAST);
    assign dctl.load = h_ab;
    assign dctl.step = b_busy_reg && (b_cnt_reg != B_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_lim_reg <= LIM_RESET;
            ang_lim_reg <= LIM_RESET;
            en_reg      <= EN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.idx)
                REG_LINEAR_LIMIT:  lin_lim_reg <= cfg.wdata[LIM_W-1:0];
                REG_ANGULAR_LIMIT: ang_lim_reg <= cfg.wdata[LIM_W-1:0];
                REG_AXIS_ENABLE:   en_reg      <= cfg.wdata[EN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_busy_reg <= 1'b0;
            a_cnt_reg  <= '0;
            b_busy_reg <= 1'b0;
            b_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd_acc)
            begin
                a_busy_reg <= 1'b1;
                a_cnt_reg  <= '0;
            end
            else if (h_ab)
            begin
                a_busy_reg <= 1'b0;
            end
            else if (a_busy_reg && (a_cnt_reg != A_LAST))
            begin
                a_cnt_reg <= a_cnt_reg + CNT_W'(1);
            end

            if (h_ab)
            begin
                b_busy_reg <= 1'b1;
                b_cnt_reg  <= '0;
            end
            else if (h_bo)
            begin
                b_busy_reg <= 1'b0;
            end
            else if (b_busy_reg && (b_cnt_reg != B_LAST))
            begin
                b_cnt_reg <= b_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_ab)
        begin
            lf_reg <= lin_cl;
            af_reg <= ang_cl;
        end
    end

    tsnl_norm_lane u_norm_lin (
        .clk   (clk),
        .ctl   (nctl),
        .vec   ({cmd.data.lin_z, cmd.data.lin_y, cmd.data.lin_x}),
        .lim   (lin_lim_reg),
        .vec_q (lin_vec),
        .prod  (lin_prod),
        .norm  (lin_norm),
        .clamp (lin_cl)
    );

    tsnl_norm_lane u_norm_ang (
        .clk   (clk),
        .ctl   (nctl),
        .vec   ({cmd.data.ang_z, cmd.data.ang_y, cmd.data.ang_x}),
        .lim   (ang_lim_reg),
        .vec_q (ang_vec),
        .prod  (ang_prod),
        .norm  (ang_norm),
        .clamp (ang_cl)
    );

    assign v6 = {ang_vec, lin_vec};
    assign p6 = {ang_prod, lin_prod};
    assign n6 = {{3{ang_norm}}, {3{lin_norm}}};
    assign c6 = {{3{ang_cl}}, {3{lin_cl}}};

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_div
        tsnl_div_lane u_div (
            .clk   (clk),
            .ctl   (dctl),
            .v     (v6[i]),
            .prod  (p6[i]),
            .d     (n6[i]),
            .clamp (c6[i]),
            .res   (r6[i])
        );
    end

    tsnl_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (h_bo),
        .comp  (r6),
        .lf    (lf_reg),
        .af    (af_reg),
        .en    (en_reg),
        .ready (rsp.ready),
        .valid (rsp.valid),
        .data  (rsp.data)
    );

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_busy_reg |-> (a_cnt_reg <= A_LAST))
        else $error("norm stage counter out of range");

    b_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        b_busy_reg |-> (b_cnt_reg <= B_LAST))
        else $error("divide stage counter out of range");

    cmd_starts_norm: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> (a_busy_reg && (a_cnt_reg == '0)))
        else $error("accepted command did not start norm stage");

    handoff_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        h_ab |=> (b_busy_reg && (b_cnt_reg == '0) && !(a_busy_reg && !$past(cmd_acc))))
        else $error("handoff did not start divide stage");

    rsp_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(h_bo))
        else $error("response raised without divide stage completion");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Twist speed norm limiter testbench
// Drives velocity commands and register writes, predicts the limited and
// masked response, and checks each response transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tsnl_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    class clamp_scoreboard;
        logic [LIM_W-1:0] lin_lim;
        logic [LIM_W-1:0] ang_lim;
        logic [EN_W-1:0]  en_mask;
        rsp_t             pending[$];
        int               mismatches;

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            if (idx == REG_LINEAR_LIMIT)
                lin_lim = v[LIM_W-1:0];
            else if (idx == REG_ANGULAR_LIMIT)
                ang_lim = v[LIM_W-1:0];
            else if (idx == REG_AXIS_ENABLE)
                en_mask = v[EN_W-1:0];
        endfunction

        function automatic logic [63:0] isqrt(logic [63:0] s);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 48;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic logic scale_triple(ref longint v[3], input logic [LIM_W-1:0] lim);
            logic [63:0] s;
            logic [63:0] n;
            logic [63:0] a;
            logic [63:0] q;
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                a = v[i] < 0 ? -v[i] : v[i];
                s = s + a * a;
            end
            if (s <= 64'(lim) * 64'(lim))
                return 1'b0;
            n = isqrt(s);
            for (int i = 0; i < 3; i++)
            begin
                a = v[i] < 0 ? -v[i] : v[i];
                q = (a * 64'(lim)) / n;
                v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1'b1;
        endfunction

        function void note_cmd(cmd_t c);
            longint lv[3];
            longint av[3];
            rsp_t   r;
            lv[0] = c.lin_x; lv[1] = c.lin_y; lv[2] = c.lin_z;
            av[0] = c.ang_x; av[1] = c.ang_y; av[2] = c.ang_z;
            r.linear_clamped  = scale_triple(lv, lin_lim);
            r.angular_clamped = scale_triple(av, ang_lim);
            for (int i = 0; i < 3; i++)
            begin
                if (!en_mask[i])
                    lv[i] = 0;
                if (!en_mask[3+i])
                    av[i] = 0;
            end
            r.out_lin_x = COMP_W'(lv[0]);
            r.out_lin_y = COMP_W'(lv[1]);
            r.out_lin_z = COMP_W'(lv[2]);
            r.out_ang_x = COMP_W'(av[0]);
            r.out_ang_y = COMP_W'(av[1]);
            r.out_ang_z = COMP_W'(av[2]);
            pending = {pending, r};
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.out_lin_x !== want.out_lin_x || got.out_lin_y !== want.out_lin_y ||
                got.out_lin_z !== want.out_lin_z || got.out_ang_x !== want.out_ang_x ||
                got.out_ang_y !== want.out_ang_y || got.out_ang_z !== want.out_ang_z ||
                got.linear_clamped !== want.linear_clamped ||
                got.angular_clamped !== want.angular_clamped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    tsnl_cmd_if cmd();
    tsnl_rsp_if rsp();
    tsnl_cfg_if cfg();
    clamp_scoreboard sb;
    int unsigned cycles;
    int          burst_left;

    twist_speed_norm_limiter_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver stall pattern: long ready stretches, short and long stalls
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            sb.check_rsp(rsp.data);
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (cycles % 1000 < 200)
            rsp.ready <= 1'b1;
        else if (cycles % 1000 < 600)
            rsp.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp.ready <= ($urandom_range(0, 9) < 3);
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.wdata <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.set_reg(idx, v);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_cmd(cmd_t c);
        if (burst_left == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 30))
                @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sb.note_cmd(c);
        burst_left--;
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
    endtask

    function automatic logic [COMP_W-1:0] rand_comp(int unsigned scale);
        case (scale)
            0: return COMP_W'($urandom);
            1: return COMP_W'($signed($urandom_range(0, 131072)) - 65536);
            2: return COMP_W'($signed($urandom_range(0, 16)) - 8);
            default:
                return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int unsigned sc;
        sc = $urandom_range(0, 3);
        c.lin_x = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sc);
        c.lin_y = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sc);
        c.lin_z = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sc);
        c.ang_x = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sc);
        c.ang_y = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sc);
        c.ang_z = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sc);
        if ($urandom_range(0, 7) == 0)
            c.lin_y = '0;
        if ($urandom_range(0, 7) == 0)
            c.ang_x = '0;
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] rand_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 23'h7FFFFF;
            2: return CFG_W'($urandom_range(1, 200));
            3: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(16384, 262144));
        endcase
    endfunction

    initial
    begin
        cmd_t c;
        cmd.valid = 1'b0;
        cmd.data  = '0;
        cfg.valid = 1'b0;
        cfg.idx   = '0;
        cfg.wdata = '0;
        sb = new();
        sb.lin_lim = LIM_RESET;
        sb.ang_lim = LIM_RESET;
        sb.en_mask = EN_RESET;
        sb.mismatches = 0;
        burst_left = 0;
        rst_n = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limits 1.0, norm at the limit, extremes, zero limit
        c = '0;
        send_cmd(c);
        c = '0; c.lin_x = 24'sd65536; c.ang_z = -24'sd65536;
        send_cmd(c);
        c = '0; c.lin_y = 24'sd65537; c.ang_y = 24'sd65537;
        send_cmd(c);
        c = {6{24'h7FFFFF}};
        send_cmd(c);
        c = {6{24'h800000}};
        send_cmd(c);
        c = {24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF};
        send_cmd(c);
        c = '0; c.lin_x = 24'sd39322; c.lin_y = 24'sd52429; c.ang_x = -24'sd1;
        send_cmd(c);
        drain();
        write_reg(REG_LINEAR_LIMIT, 23'd0);
        write_reg(REG_ANGULAR_LIMIT, 23'h7FFFFF);
        write_reg(REG_AXIS_ENABLE, 23'h7FFFC5);
        c = '0; c.lin_z = 24'sd1; c.ang_x = 24'h800000;
        send_cmd(c);
        c = {6{24'h800000}};
        send_cmd(c);
        c = '0;
        send_cmd(c);
        c = {6{24'h7FFFFF}};
        send_cmd(c);
        c = '0; c.lin_x = 24'h000003; c.lin_y = 24'h000004;
        send_cmd(c);
        drain();
        write_reg(REG_LINEAR_LIMIT, 23'd5);
        write_reg(REG_ANGULAR_LIMIT, 23'd0);
        write_reg(REG_AXIS_ENABLE, 23'd0);
        write_reg(REG_UNUSED, 23'h7FFFFF);
        send_cmd(c);
        c = '0; c.lin_x = -24'sd3; c.lin_y = 24'sd4; c.lin_z = 24'sd1; c.ang_y = 24'sd2;
        send_cmd(c);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_LINEAR_LIMIT, rand_limit());
            write_reg(REG_ANGULAR_LIMIT, rand_limit());
            write_reg(REG_AXIS_ENABLE, phase == 0 ? 23'h3F : CFG_W'($urandom));
            for (int i = 0; i < 75; i++)
                send_cmd(rand_cmd());
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

### files.f
rtl/tsnl_pkg.sv
rtl/tsnl_if.sv
rtl/tsnl_norm_lane.sv
rtl/tsnl_div_lane.sv
rtl/tsnl_merge.sv
rtl/twist_speed_norm_limiter_unit.sv
tb/testbench.sv
